>>> rtl/core/multi_channel_rate_accumulator_top_defines.svh
// assertion macros for the rate accumulator block
// no dependencies; included by the modules that carry assertions
`ifndef MULTI_CHANNEL_RATE_ACCUMULATOR_TOP_DEFINES_SVH
`define MULTI_CHANNEL_RATE_ACCUMULATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MCRA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MCRA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MCRA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MCRA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/mcra_pkg.sv
// shared types and constants of the rate accumulator block
// no dependencies
package mcra_pkg;

  localparam int OP_W   = 3;
  localparam int CH_W   = 3;
  localparam int DATA_W = 32;
  localparam int MASK_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_POLL   = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_CREATE = 3'd3,
    OP_SETPER = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic we;
    logic fire;
    logic hit;
  } upd_t;

endpackage

>>> rtl/core/mcra_if.sv
// item channels of the rate accumulator block: command in, result out
// depends on mcra_pkg
interface mcra_cmd_if;
  import mcra_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CH_W-1:0]   channel;
  logic [DATA_W-1:0] amount;
  logic [DATA_W-1:0] period;
  logic              notify_mode;
  modport source (output valid, operation, channel, amount, period, notify_mode,
                  input ready);
  modport sink (input valid, operation, channel, amount, period, notify_mode,
                output ready);
endinterface

interface mcra_res_if;
  import mcra_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] fired_mask;
  logic              poll_hit;
  modport source (output valid, fired_mask, poll_hit, input ready);
  modport sink (input valid, fired_mask, poll_hit, output ready);
endinterface

>>> rtl/core/multi_channel_rate_accumulator_top.sv
// one command at a time: cmd.ready is high only in S_IDLE, so a new item waits
// until the last has left S_DONE; a tick sweeps the count memory once,
// one channel per cycle through its single read port and a two-stage update
// reset: clears all present and notify bits; count and period memories are not cleared
// top level; depends on mcra_pkg, mcra_if, mcra_update and the defines header
`include "multi_channel_rate_accumulator_top_defines.svh"
module multi_channel_rate_accumulator_top #(
  parameter int COUNTERS = 8
) (
  input logic        clk,
  input logic        rst,
  mcra_cmd_if.sink   cmd,
  mcra_res_if.source res
);
  import mcra_pkg::*;

  localparam int IW = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;
  localparam int CW = (IW > CH_W) ? IW : CH_W;

  state_t state;

  logic [DATA_W-1:0] count_mem [COUNTERS];
  logic [DATA_W-1:0] period_mem [COUNTERS];
  logic [DATA_W-1:0] count_q;
  logic [DATA_W-1:0] period_q;
  logic [COUNTERS-1:0] present;
  logic [COUNTERS-1:0] notify;

  logic          iss_on;
  logic [IW-1:0] iss_idx;
  logic          p1_vld;
  logic [IW-1:0] p1_idx;
  logic          p2_vld;
  logic [IW-1:0] p2_idx;
  logic [DATA_W-1:0] p2_sum;
  logic [DATA_W-1:0] p2_period;

  logic              tick_r;
  logic [DATA_W-1:0] amount_r;
  logic [MASK_W-1:0] mask_r;
  logic              hit_r;

  logic              out_vld;
  logic [MASK_W-1:0] fired_q;
  logic              hit_q;

  logic              acc;
  logic [CW-1:0]     ch_ext;
  logic [IW-1:0]     ch_idx;
  logic              ch_ok;
  logic [DATA_W:0]   wide_sum;
  logic [DATA_W-1:0] sat_sum;
  logic [DATA_W-1:0] upd_count;
  upd_t              upd;

  logic              cnt_we;
  logic [IW-1:0]     cnt_waddr;
  logic [DATA_W-1:0] cnt_wdata;
  logic              per_we;

  assign cmd.ready      = (state == S_IDLE);
  assign res.valid      = out_vld;
  assign res.fired_mask = fired_q;
  assign res.poll_hit   = hit_q;

  always_comb begin
    acc      = cmd.valid && (state == S_IDLE);
    ch_ext   = CW'(cmd.channel);
    ch_idx   = ch_ext[IW-1:0];
    ch_ok    = 32'(cmd.channel) < COUNTERS;
    wide_sum = {1'b0, count_q} + {1'b0, (tick_r ? amount_r : {DATA_W{1'b0}})};
    sat_sum  = wide_sum[DATA_W] ? {DATA_W{1'b1}} : wide_sum[DATA_W-1:0];
  end

  mcra_update u_update (
    .sum        (p2_sum),
    .period     (p2_period),
    .present    (present[p2_idx]),
    .notify     (notify[p2_idx]),
    .is_tick    (tick_r),
    .count_next (upd_count),
    .upd        (upd)
  );

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = p2_idx;
    cnt_wdata = upd_count;
    per_we    = 1'b0;
    if (p2_vld) begin
      cnt_we = upd.we;
    end else if (acc && ch_ok) begin
      cnt_waddr = ch_idx;
      cnt_wdata = '0;
      case (cmd.operation)
        OP_CLEAR:  cnt_we = present[ch_idx];
        OP_CREATE: begin
          cnt_we = 1'b1;
          per_we = 1'b1;
        end
        OP_SETPER: per_we = present[ch_idx];
        default:   cnt_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
    count_q <= count_mem[iss_idx];
  end

  always_ff @(posedge clk) begin
    if (per_we) begin
      period_mem[ch_idx] <= cmd.period;
    end
    period_q <= period_mem[iss_idx];
  end

  always_ff @(posedge clk) begin
    p1_idx    <= iss_idx;
    p2_idx    <= p1_idx;
    p2_sum    <= sat_sum;
    p2_period <= period_q;
    if (rst) begin
      state   <= S_IDLE;
      iss_on  <= 1'b0;
      iss_idx <= '0;
      p1_vld  <= 1'b0;
      p2_vld  <= 1'b0;
      out_vld <= 1'b0;
      present <= '0;
      notify  <= '0;
    end else begin
      p1_vld <= iss_on;
      p2_vld <= p1_vld;
      if (out_vld && res.ready && (state != S_DONE)) begin
        out_vld <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            tick_r   <= (cmd.operation == OP_TICK);
            amount_r <= cmd.amount;
            mask_r   <= '0;
            hit_r    <= 1'b0;
            case (cmd.operation)
              OP_TICK: begin
                iss_on  <= 1'b1;
                iss_idx <= '0;
                state   <= S_RUN;
              end
              OP_POLL: begin
                if (ch_ok) begin
                  iss_on  <= 1'b1;
                  iss_idx <= ch_idx;
                  state   <= S_RUN;
                end else begin
                  state <= S_DONE;
                end
              end
              OP_CREATE: begin
                if (ch_ok) begin
                  present[ch_idx] <= 1'b1;
                  notify[ch_idx]  <= cmd.notify_mode;
                end
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RUN: begin
          if (iss_on) begin
            if (tick_r && (iss_idx != IW'(COUNTERS - 1))) begin
              iss_idx <= iss_idx + 1'b1;
            end else begin
              iss_on <= 1'b0;
            end
          end
          if (p2_vld) begin
            hit_r <= hit_r | upd.hit;
            if (upd.fire && (32'(p2_idx) < MASK_W)) begin
              mask_r <= mask_r | (MASK_W'(1) << p2_idx);
            end
          end
          if (p2_vld && !p1_vld && !iss_on) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_vld || res.ready) begin
            out_vld <= 1'b1;
            fired_q <= mask_r;
            hit_q   <= hit_r;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MCRA_ASSERT_IMP(a_run_busy, clk, rst, state == S_RUN, iss_on || p1_vld || p2_vld)
  `MCRA_ASSERT_IMP(a_out_from_done, clk, rst, $rose(out_vld), $past(state == S_DONE))
  `MCRA_ASSERT_IMP(a_no_hazard, clk, rst, p1_vld && p2_vld, p1_idx != p2_idx)
  `MCRA_ASSERT_NXT(a_tick_runs, clk, rst, acc && cmd.operation == OP_TICK, state == S_RUN && iss_on && iss_idx == '0)

endmodule

>>> rtl/core/mcra_update.sv
// per-channel test and subtract after the saturating add
// depends on mcra_pkg
module mcra_update (
  input  logic [mcra_pkg::DATA_W-1:0] sum,
  input  logic [mcra_pkg::DATA_W-1:0] period,
  input  logic                        present,
  input  logic                        notify,
  input  logic                        is_tick,
  output logic [mcra_pkg::DATA_W-1:0] count_next,
  output mcra_pkg::upd_t              upd
);
  import mcra_pkg::*;

  logic reduce;
  logic take;

  always_comb begin
    reduce     = sum > period;
    take       = reduce && (is_tick ? notify : 1'b1);
    count_next = take ? (sum - period) : sum;
    upd.we     = present;
    upd.fire   = is_tick && present && notify && reduce;
    upd.hit    = !is_tick && present && reduce;
  end

endmodule
